/* rtl/spectrum_channel_color_and_height_macros.svh */
// Assertion macros shared by the spectrum channel colour and height block.
`ifndef SPECTRUM_CHANNEL_COLOR_AND_HEIGHT_MACROS_SVH
`define SPECTRUM_CHANNEL_COLOR_AND_HEIGHT_MACROS_SVH
// The consequent must hold in the same cycle as the antecedent.
`define SCCH_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// The consequent must hold a fixed number of cycles after the antecedent.
`define SCCH_ASSERT_AFTER(label, ante, cycles, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |-> ##cycles (cons)) else $error(msg);
`endif

/* rtl/scch_pkg.sv */
// Package with the constants, types and tables of the spectrum channel colour block.
package scch_pkg;

   localparam int CHANNEL_BITS      = 9;
   localparam int GAMMA_TABLE_DEPTH = 1024;
   localparam int GAMMA_IDX_BITS    = $clog2(GAMMA_TABLE_DEPTH);

   localparam int SAMPLE_BITS   = 12;
   localparam int DARK_BITS     = 12;
   localparam int SCALE_BITS    = 8;
   localparam int PIXEL_BITS    = 16;
   localparam int BAR_BITS      = 12;
   localparam int WAVE_BITS     = 24;
   localparam int Q16_BITS      = 17;
   localparam int NUM_BITS      = 28;
   localparam int DEN_BITS      = 11;
   localparam int RECIP_BITS    = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Pipeline depth from an accepted word to its result strobe.
   localparam int LATENCY = BAR_BITS + 1;

   // Calibration polynomial coefficients, scaled by 2^76, 2^56 or 2^48.
   localparam logic signed [63:0] CB5 = 64'sd379864423932;
   localparam logic signed [63:0] CB4 = 64'sd634459652128000;
   localparam logic signed [63:0] CB3 = -64'sd501601040698;
   localparam logic signed [63:0] CB2 = -64'sd95833305525184;
   localparam logic signed [63:0] CB1 = 64'sd764002075426585;
   localparam logic signed [63:0] CA0 = 64'sd87512705218903803;
   localparam logic signed [63:0] ROUND_40 = 64'sd549755813888;

   // Band edges in nanometres as Q8.
   localparam logic signed [WAVE_BITS-1:0] NM_350 = 24'sd89600;
   localparam logic signed [WAVE_BITS-1:0] NM_420 = 24'sd107520;
   localparam logic signed [WAVE_BITS-1:0] NM_440 = 24'sd112640;
   localparam logic signed [WAVE_BITS-1:0] NM_490 = 24'sd125440;
   localparam logic signed [WAVE_BITS-1:0] NM_510 = 24'sd130560;
   localparam logic signed [WAVE_BITS-1:0] NM_580 = 24'sd148480;
   localparam logic signed [WAVE_BITS-1:0] NM_645 = 24'sd165120;
   localparam logic signed [WAVE_BITS-1:0] NM_701 = 24'sd179456;
   localparam logic signed [WAVE_BITS-1:0] NM_850 = 24'sd217600;
   localparam logic signed [WAVE_BITS-1:0] NM_149 = 24'sd38144;
   localparam logic signed [WAVE_BITS-1:0] NM_70  = 24'sd17920;

   // Divisors of the reduced ratio forms and their reciprocals scaled by 2^32.
   localparam logic [DEN_BITS-1:0] DEN_90   = 11'd180;
   localparam logic [DEN_BITS-1:0] DEN_50   = 11'd100;
   localparam logic [DEN_BITS-1:0] DEN_20   = 11'd40;
   localparam logic [DEN_BITS-1:0] DEN_70   = 11'd140;
   localparam logic [DEN_BITS-1:0] DEN_65   = 11'd130;
   localparam logic [DEN_BITS-1:0] DEN_HIGH = 11'd1490;
   localparam logic [DEN_BITS-1:0] DEN_LOW  = 11'd700;

   localparam logic [RECIP_BITS-1:0] RECIP_90   = 32'(64'h1_0000_0000 / 64'd180);
   localparam logic [RECIP_BITS-1:0] RECIP_50   = 32'(64'h1_0000_0000 / 64'd100);
   localparam logic [RECIP_BITS-1:0] RECIP_20   = 32'(64'h1_0000_0000 / 64'd40);
   localparam logic [RECIP_BITS-1:0] RECIP_70   = 32'(64'h1_0000_0000 / 64'd140);
   localparam logic [RECIP_BITS-1:0] RECIP_65   = 32'(64'h1_0000_0000 / 64'd130);
   localparam logic [RECIP_BITS-1:0] RECIP_HIGH = 32'(64'h1_0000_0000 / 64'd1490);
   localparam logic [RECIP_BITS-1:0] RECIP_LOW  = 32'(64'h1_0000_0000 / 64'd700);

   localparam logic [Q16_BITS-1:0] Q16_ONE = 17'h10000;

   typedef logic [1:0] comp_sel_type;
   localparam comp_sel_type COMP_ZERO  = 2'd0;
   localparam comp_sel_type COMP_ONE   = 2'd1;
   localparam comp_sel_type COMP_RATIO = 2'd2;

   typedef struct packed {
      comp_sel_type r;
      comp_sel_type g;
      comp_sel_type b;
      comp_sel_type f;
   } colour_sel_type;

   typedef struct packed {
      logic [DARK_BITS-1:0]  dark_level;
      logic [SCALE_BITS-1:0] scale_divisor;
   } cfg_type;

   localparam logic REG_DARK_LEVEL    = 1'b0;
   localparam logic REG_SCALE_DIVISOR = 1'b1;
   localparam logic [DARK_BITS-1:0]  DARK_RESET  = 12'd550;
   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 8'd20;

   typedef logic [7:0] gamma_rom_type [GAMMA_TABLE_DEPTH];

   // Entry i is the largest k with (2k-1)^5 * (D-1)^4 <= 510^5 * i^4.
   function automatic gamma_rom_type build_gamma_rom();
      gamma_rom_type rom;
      logic [127:0]  d4;
      logic [127:0]  p;
      logic [127:0]  rhs;
      logic [127:0]  lhs;
      logic [127:0]  t;
      int            lo;
      int            hi;
      int            mid;
      d4 = 128'(GAMMA_TABLE_DEPTH - 1);
      d4 = d4 * d4 * d4 * d4;
      for (int i = 0; i < GAMMA_TABLE_DEPTH; i++) begin
         p   = 128'(i);
         rhs = 128'd34502525100000 * p * p * p * p;
         lo  = 0;
         hi  = 255;
         while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            t   = 128'(2 * mid - 1);
            lhs = t * t * t * t * t * d4;
            if (lhs <= rhs) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
         rom[i] = 8'(lo);
      end
      return rom;
   endfunction

   localparam gamma_rom_type GAMMA_ROM = build_gamma_rom();

endpackage

/* rtl/scch_wavelength.sv */
// Five-stage Horner pipeline turning a channel number into a Q8 wavelength.
module scch_wavelength (
   input  logic                                 clock,
   input  logic [scch_pkg::CHANNEL_BITS-1:0]    channel,
   output logic signed [scch_pkg::WAVE_BITS-1:0] wavelength
);

   localparam int CB = scch_pkg::CHANNEL_BITS;
   localparam int WB = scch_pkg::WAVE_BITS;

   logic [CB-1:0]        x_ff [4];
   logic signed [63:0]   acc1_ff, acc1_in;
   logic signed [63:0]   acc2_ff, acc2_in;
   logic signed [63:0]   acc3_ff, acc3_in;
   logic signed [63:0]   acc4_ff, acc4_in;
   logic signed [63:0]   acc5;
   logic signed [WB-1:0] wave_ff, wave_in;

   always_comb begin
      acc1_in = scch_pkg::CB5 * $signed({1'b0, channel}) + scch_pkg::CB4;
      acc2_in = ((acc1_ff * $signed({1'b0, x_ff[0]})) >>> 20) + scch_pkg::CB3;
      acc3_in = acc2_ff * $signed({1'b0, x_ff[1]}) + scch_pkg::CB2;
      acc4_in = ((acc3_ff * $signed({1'b0, x_ff[2]})) >>> 8) + scch_pkg::CB1;
      acc5    = acc4_ff * $signed({1'b0, x_ff[3]}) + scch_pkg::CA0 + scch_pkg::ROUND_40;
      // The top bits of the rounded sum are the arithmetic shift by 40.
      wave_in = $signed(acc5[WB+39:40]);
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= channel;
      for (int k = 1; k < 4; k++) begin
         x_ff[k] <= x_ff[k-1];
      end
      acc1_ff <= acc1_in;
      acc2_ff <= acc2_in;
      acc3_ff <= acc3_in;
      acc4_ff <= acc4_in;
      wave_ff <= wave_in;
   end

   assign wavelength = wave_ff;

endmodule

/* rtl/scch_colour.sv */
// Eight-stage pipeline from a Q8 wavelength to an RGB565 colour with gamma.
module scch_colour (
   input  logic                                  clock,
   input  logic signed [scch_pkg::WAVE_BITS-1:0] wavelength,
   output logic [scch_pkg::PIXEL_BITS-1:0]       pixel_color
);

   localparam int WB = scch_pkg::WAVE_BITS;
   localparam int NB = scch_pkg::NUM_BITS;
   localparam int DB = scch_pkg::DEN_BITS;
   localparam int RB = scch_pkg::RECIP_BITS;
   localparam int QB = scch_pkg::Q16_BITS;
   localparam int GI = scch_pkg::GAMMA_IDX_BITS;
   localparam int PB = 2 * QB;
   localparam int IB = PB + GI;

   // Band decode.
   logic [WB-1:0]            cnum, fnum;
   logic [DB-1:0]            cden, fden;
   logic [RB-1:0]            crec, frec;
   scch_pkg::colour_sel_type sel_in;
   logic [NB-1:0]            nc_ff, nc_in, nf_ff, nf_in;
   logic [DB-1:0]            dc_ff [3];
   logic [DB-1:0]            df_ff [3];
   logic [RB-1:0]            rc_ff, rf_ff;
   scch_pkg::colour_sel_type sel_ff [3];

   // Reciprocal quotient and correction.
   logic [NB+RB-1:0] pc, pf;
   logic [QB-1:0]    qc0_ff, qf0_ff, qc0b_ff, qf0b_ff;
   logic [NB-1:0]    nc2_ff, nf2_ff;
   logic [NB-1:0]    remc_wide, remf_wide;
   logic [DB:0]      remc_ff, remf_ff;

   // Components, products, indices, gamma and packing.
   logic [QB-1:0] comp_ff [3];
   logic [QB-1:0] comp_in [3];
   logic [QB-1:0] fac_ff, fac_in;
   logic [QB-1:0] qc, qf;
   logic [PB-1:0] prod_ff [3];
   logic [IB-1:0] idx_wide [3];
   logic [GI-1:0] idx_ff [3];
   logic [7:0]    gam_ff [3];
   logic [13:0]   scaled [3];
   logic [13:0]   folded [3];
   logic [5:0]    chan [3];
   logic [scch_pkg::PIXEL_BITS-1:0] pixel_ff, pixel_in;

   function automatic logic [QB-1:0] comp_value(scch_pkg::comp_sel_type s, logic [QB-1:0] q);
      logic [QB-1:0] v;
      case (s)
         scch_pkg::COMP_ONE:   v = scch_pkg::Q16_ONE;
         scch_pkg::COMP_RATIO: v = q;
         default:              v = '0;
      endcase
      return v;
   endfunction

   // Each ratio is reduced to floor(N / D) with N = num * scale + D / 2.
   always_comb begin
      cnum   = '0;
      cden   = scch_pkg::DEN_90;
      crec   = scch_pkg::RECIP_90;
      sel_in = '{scch_pkg::COMP_ZERO, scch_pkg::COMP_ZERO, scch_pkg::COMP_ZERO,
                 scch_pkg::COMP_ZERO};
      if (wavelength >= scch_pkg::NM_350 && wavelength < scch_pkg::NM_440) begin
         cnum     = WB'(scch_pkg::NM_440 - wavelength);
         sel_in.r = scch_pkg::COMP_RATIO;
         sel_in.b = scch_pkg::COMP_ONE;
      end else if (wavelength >= scch_pkg::NM_440 && wavelength < scch_pkg::NM_490) begin
         cnum     = WB'(wavelength - scch_pkg::NM_440);
         cden     = scch_pkg::DEN_50;
         crec     = scch_pkg::RECIP_50;
         sel_in.g = scch_pkg::COMP_RATIO;
         sel_in.b = scch_pkg::COMP_ONE;
      end else if (wavelength >= scch_pkg::NM_490 && wavelength < scch_pkg::NM_510) begin
         cnum     = WB'(scch_pkg::NM_510 - wavelength);
         cden     = scch_pkg::DEN_20;
         crec     = scch_pkg::RECIP_20;
         sel_in.g = scch_pkg::COMP_ONE;
         sel_in.b = scch_pkg::COMP_RATIO;
      end else if (wavelength >= scch_pkg::NM_510 && wavelength < scch_pkg::NM_580) begin
         cnum     = WB'(wavelength - scch_pkg::NM_510);
         cden     = scch_pkg::DEN_70;
         crec     = scch_pkg::RECIP_70;
         sel_in.r = scch_pkg::COMP_RATIO;
         sel_in.g = scch_pkg::COMP_ONE;
      end else if (wavelength >= scch_pkg::NM_580 && wavelength < scch_pkg::NM_645) begin
         cnum     = WB'(scch_pkg::NM_645 - wavelength);
         cden     = scch_pkg::DEN_65;
         crec     = scch_pkg::RECIP_65;
         sel_in.r = scch_pkg::COMP_ONE;
         sel_in.g = scch_pkg::COMP_RATIO;
      end else if (wavelength >= scch_pkg::NM_645 && wavelength <= scch_pkg::NM_850) begin
         sel_in.r = scch_pkg::COMP_ONE;
      end

      fnum = '0;
      fden = scch_pkg::DEN_HIGH;
      frec = scch_pkg::RECIP_HIGH;
      if (wavelength >= scch_pkg::NM_701 && wavelength < scch_pkg::NM_850) begin
         fnum     = WB'(3 * scch_pkg::NM_149 + 7 * (scch_pkg::NM_850 - wavelength));
         sel_in.f = scch_pkg::COMP_RATIO;
      end else if (wavelength >= scch_pkg::NM_420 && wavelength < scch_pkg::NM_701) begin
         sel_in.f = scch_pkg::COMP_ONE;
      end else if (wavelength >= scch_pkg::NM_350 && wavelength < scch_pkg::NM_420) begin
         fnum     = WB'(3 * scch_pkg::NM_70 + 7 * (wavelength - scch_pkg::NM_350));
         fden     = scch_pkg::DEN_LOW;
         frec     = scch_pkg::RECIP_LOW;
         sel_in.f = scch_pkg::COMP_RATIO;
      end

      nc_in = (NB'(cnum) << 9) + NB'(cden >> 1);
      nf_in = (NB'(fnum) << 8) + NB'(fden >> 1);
   end

   // The reciprocal estimate is low by at most one, so one compare fixes it.
   always_comb begin
      pc        = (NB+RB)'(nc_ff) * (NB+RB)'(rc_ff);
      pf        = (NB+RB)'(nf_ff) * (NB+RB)'(rf_ff);
      remc_wide = nc2_ff - NB'(qc0_ff) * NB'(dc_ff[1]);
      remf_wide = nf2_ff - NB'(qf0_ff) * NB'(df_ff[1]);
      qc        = qc0b_ff + QB'(remc_ff >= {1'b0, dc_ff[2]});
      qf        = qf0b_ff + QB'(remf_ff >= {1'b0, df_ff[2]});
      comp_in[0] = comp_value(sel_ff[2].r, qc);
      comp_in[1] = comp_value(sel_ff[2].g, qc);
      comp_in[2] = comp_value(sel_ff[2].b, qc);
      fac_in     = comp_value(sel_ff[2].f, qf);
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         idx_wide[k] = IB'(prod_ff[k]) * IB'(scch_pkg::GAMMA_TABLE_DEPTH - 1)
                     + IB'(64'h8000_0000);
         scaled[k]   = (k == 1) ? 14'(gam_ff[k] * 63) : 14'(gam_ff[k] * 31);
         // Division by 255 of a value below 65535.
         folded[k]   = scaled[k] + 14'(scaled[k] >> 8) + 14'd1;
         chan[k]     = folded[k][13:8];
      end
      pixel_in = {chan[0][4:0], chan[1], chan[2][4:0]};
   end

   always_ff @(posedge clock) begin
      nc_ff     <= nc_in;
      nf_ff     <= nf_in;
      dc_ff[0]  <= cden;
      df_ff[0]  <= fden;
      rc_ff     <= crec;
      rf_ff     <= frec;
      sel_ff[0] <= sel_in;
      for (int k = 1; k < 3; k++) begin
         dc_ff[k]  <= dc_ff[k-1];
         df_ff[k]  <= df_ff[k-1];
         sel_ff[k] <= sel_ff[k-1];
      end
      qc0_ff  <= pc[RB +: QB];
      qf0_ff  <= pf[RB +: QB];
      nc2_ff  <= nc_ff;
      nf2_ff  <= nf_ff;
      qc0b_ff <= qc0_ff;
      qf0b_ff <= qf0_ff;
      remc_ff <= remc_wide[DB:0];
      remf_ff <= remf_wide[DB:0];
      fac_ff  <= fac_in;
      for (int k = 0; k < 3; k++) begin
         comp_ff[k] <= comp_in[k];
         prod_ff[k] <= comp_ff[k] * fac_ff;
         idx_ff[k]  <= idx_wide[k][32 +: GI];
         gam_ff[k]  <= scch_pkg::GAMMA_ROM[idx_ff[k]];
      end
      pixel_ff <= pixel_in;
   end

   assign pixel_color = pixel_ff;

endmodule

/* rtl/spectrum_channel_color_and_height.sv */
// Top level of the spectrum channel colour and bar height block.
//
// A word is taken at each rising edge where start is high and busy is low.
// busy stays low, so one word may be given in every cycle. Each word
// carries a channel number and a raw sample. When it has passed both
// pipelines, rsp_strobe is high for one cycle with the RGB565 colour of the
// channel's wavelength and the dark-corrected bar height.
// The colour path is a five-stage calibration polynomial followed by eight
// stages of band decode, reciprocal ratios, gamma lookup and packing. The
// bar height comes from a restoring divider with one quotient bit a stage,
// twelve stages after the dark subtraction, so both paths end together.
// Throughput is one word a cycle, since busy is never raised.
// Reset clears the valid bits, so words in flight are dropped, and sets
// dark_level to 550 and scale_divisor to 20. The receiver cannot stall:
// every result is shown for exactly one cycle. The APB port at byte
// addresses 0 and 4 writes and reads the two registers; write them only
// while no word is in flight.
`include "spectrum_channel_color_and_height_macros.svh"

module spectrum_channel_color_and_height (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [scch_pkg::CHANNEL_BITS-1:0]      req_channel_number,
   input  logic [scch_pkg::SAMPLE_BITS-1:0]       req_sample_value,
   output logic                                   rsp_strobe,
   output logic [scch_pkg::PIXEL_BITS-1:0]        rsp_pixel_color,
   output logic [scch_pkg::BAR_BITS-1:0]          rsp_bar_height,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [scch_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [scch_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic [scch_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                   pready
);

   localparam int LAT = scch_pkg::LATENCY;
   localparam int BB  = scch_pkg::BAR_BITS;
   localparam int SB  = scch_pkg::SCALE_BITS;
   localparam int DW  = scch_pkg::CSR_DATA_BITS;

   scch_pkg::cfg_type cfg_ff, cfg_in;
   logic              accept;
   logic              csr_write;
   logic [LAT-1:0]    valid_ff, valid_in;

   logic signed [scch_pkg::WAVE_BITS-1:0] wavelength;

   logic [BB-1:0] dq_ff  [LAT];
   logic [BB-1:0] dq_in  [LAT];
   logic [SB-1:0] rem_ff [LAT];
   logic [SB-1:0] rem_in [LAT];
   logic [SB-1:0] div_ff [LAT];
   logic [SB:0]   trial  [LAT-1];
   logic [SB:0]   diff   [LAT-1];
   logic          fits   [LAT-1];

   assign busy      = 1'b0;
   assign pready    = 1'b1;
   assign accept    = start && !busy;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (paddr[2])
            scch_pkg::REG_DARK_LEVEL:    cfg_in.dark_level    = pwdata[scch_pkg::DARK_BITS-1:0];
            scch_pkg::REG_SCALE_DIVISOR: cfg_in.scale_divisor = pwdata[SB-1:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         scch_pkg::REG_DARK_LEVEL:    prdata = DW'(cfg_ff.dark_level);
         scch_pkg::REG_SCALE_DIVISOR: prdata = DW'(cfg_ff.scale_divisor);
         default:                     prdata = '0;
      endcase
   end

   assign valid_in = {valid_ff[LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dark_level    <= scch_pkg::DARK_RESET;
         cfg_ff.scale_divisor <= scch_pkg::SCALE_RESET;
         valid_ff             <= '0;
      end else begin
         cfg_ff   <= cfg_in;
         valid_ff <= valid_in;
      end
   end

   scch_wavelength u_wavelength (
      .clock      (clock),
      .channel    (req_channel_number),
      .wavelength (wavelength)
   );

   scch_colour u_colour (
      .clock       (clock),
      .wavelength  (wavelength),
      .pixel_color (rsp_pixel_color)
   );

   // Each divider stage brings down one dividend bit and forms one quotient bit.
   always_comb begin
      dq_in[0]  = (req_sample_value > cfg_ff.dark_level)
                ? BB'(req_sample_value - cfg_ff.dark_level) : '0;
      rem_in[0] = '0;
      for (int j = 0; j < LAT - 1; j++) begin
         trial[j]    = {rem_ff[j], dq_ff[j][BB-1]};
         fits[j]     = trial[j] >= {1'b0, div_ff[j]};
         diff[j]     = trial[j] - {1'b0, div_ff[j]};
         rem_in[j+1] = fits[j] ? diff[j][SB-1:0] : trial[j][SB-1:0];
         dq_in[j+1]  = {dq_ff[j][BB-2:0], fits[j]};
      end
   end

   always_ff @(posedge clock) begin
      div_ff[0] <= (cfg_ff.scale_divisor == '0) ? SB'(1) : cfg_ff.scale_divisor;
      for (int j = 1; j < LAT; j++) begin
         div_ff[j] <= div_ff[j-1];
      end
      for (int j = 0; j < LAT; j++) begin
         dq_ff[j]  <= dq_in[j];
         rem_ff[j] <= rem_in[j];
      end
   end

   assign rsp_strobe     = valid_ff[LAT-1];
   assign rsp_bar_height = dq_ff[LAT-1];

   `SCCH_ASSERT_AFTER(a_result_follows, accept, 13, rsp_strobe, "result strobe missing")
   `SCCH_ASSERT_IMPLIES(a_bar_bounded, rsp_strobe, rsp_bar_height <= $past(req_sample_value, 13), "bar height above sample")
   `SCCH_ASSERT_IMPLIES(a_rem_below_div, valid_ff[LAT-1], rem_ff[LAT-1] < div_ff[LAT-1], "divider remainder too large")

endmodule
